### rtl/core/afg_pkg.sv
// ----------------------------------------------------------------------------
// afg_pkg
// Shared types and constants for the Apery set / Frobenius / genus block.
// ----------------------------------------------------------------------------
package afg_pkg;

  localparam int unsigned MAX_GENERATORS_DEF   = 16;
  localparam int unsigned MAX_MULTIPLICITY_DEF = 64;
  localparam int unsigned GENERATOR_WIDTH_DEF  = 12;

  // Depth of the command queue between the front and the back.
  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  localparam int unsigned FROB_W   = 19;
  localparam int unsigned GENUS_W  = 18;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_TDATA_W = ((FROB_W + GENUS_W + STATUS_W + 7) / 8) * 8;

  localparam logic [31:0] RANGE_MAX = 32'd262143;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNREACH  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Classification of one accepted item.
  typedef struct packed {
    logic store;  // nonzero generator, goes into the store
    logic last;   // closes the set and starts the evaluation
  } cmd_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GM_RD,
    S_GM_ST,
    S_GM_DIV,
    S_INIT,
    S_R_RD,
    S_R_CHK,
    S_K_RD,
    S_K_CALC,
    S_K_UPD,
    S_SW_RD,
    S_SW_CHK,
    S_SW_DIV,
    S_FIN
  } back_state_e;

endpackage

### rtl/core/afg_front.sv
// ----------------------------------------------------------------------------
// afg_front
// Accepts generator items and turns them into queue commands.
// ----------------------------------------------------------------------------
module afg_front #(
  parameter int unsigned GenWidth = afg_pkg::GENERATOR_WIDTH_DEF,
  parameter int unsigned TdataW   = ((GenWidth + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [TdataW-1:0]    s_tdata_i,
  input  logic                 s_tlast_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_full_i,
  output logic [GenWidth-1:0]  cmd_gen_o,
  output afg_pkg::cmd_ctl_t    cmd_ctl_o
);
  import afg_pkg::*;

  logic [GenWidth-1:0] gen;
  logic                take;

  assign gen        = s_tdata_i[GenWidth-1:0];
  assign s_tready_o = !cmd_full_i;
  assign take       = s_tvalid_i && !cmd_full_i;

  // A zero generator adds nothing; it is only forwarded when it closes the set.
  always_comb begin
    cmd_ctl_o.store = (gen != '0);
    cmd_ctl_o.last  = s_tlast_i;
    cmd_valid_o     = take && ((gen != '0) || s_tlast_i);
    cmd_gen_o       = gen;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (cmd_ctl_o.store || cmd_ctl_o.last))
    else $error("front pushed an empty command");

endmodule

### rtl/core/afg_queue.sv
// ----------------------------------------------------------------------------
// afg_queue
// Small command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module afg_queue #(
  parameter int unsigned Width = 14,
  parameter int unsigned Depth = afg_pkg::CMD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o
);
  import afg_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count beyond depth");

endmodule

### rtl/core/afg_div.sv
// ----------------------------------------------------------------------------
// afg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afg_div #(
  parameter int unsigned DivdW = 18,
  parameter int unsigned DivsW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DivsW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivdW-1:0] quo_o,
  output logic [DivsW-1:0] rem_o
);
  import afg_pkg::*;

  localparam int unsigned SCW = $clog2(DivdW + 1);

  logic [DivdW-1:0] quo_q, quo_d;
  logic [DivsW-1:0] rem_q, rem_d;
  logic [SCW-1:0]   step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivsW:0]   trial;

  assign trial = {rem_q, quo_q[DivdW-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DivsW'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[DivdW-2:0], 1'b1};
      end else begin
        rem_d = DivsW'(trial);
        quo_d = {quo_q[DivdW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == SCW'(DivdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

### rtl/core/afg_back.sv
// ----------------------------------------------------------------------------
// afg_back
// Generator store, Apery relaxation, Frobenius and genus evaluation.
// ----------------------------------------------------------------------------
module afg_back #(
  parameter int unsigned MaxGen   = afg_pkg::MAX_GENERATORS_DEF,
  parameter int unsigned MaxMult  = afg_pkg::MAX_MULTIPLICITY_DEF,
  parameter int unsigned GenWidth = afg_pkg::GENERATOR_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  logic [GenWidth-1:0]                 cmd_gen_i,
  input  afg_pkg::cmd_ctl_t                   cmd_ctl_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [afg_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);
  import afg_pkg::*;

  localparam int unsigned RW  = $clog2(MaxMult);
  localparam int unsigned MW  = $clog2(MaxMult + 1);
  localparam int unsigned TW  = GenWidth + RW;
  localparam int unsigned KW  = $clog2(MaxGen);
  localparam int unsigned CNW = $clog2(MaxGen + 1);
  localparam int unsigned SW  = TW + RW + 1;
  localparam int unsigned CW  = ((TW > FROB_W) ? TW : FROB_W) + 1;
  localparam logic [TW-1:0] INF = {TW{1'b1}};

  back_state_e state_q, state_d;

  logic [CNW-1:0]      cnt_q, cnt_d;
  logic [GenWidth-1:0] min_q, min_d;
  logic                ovf_q, ovf_d;
  logic [KW-1:0]       k_q, k_d;
  logic [RW-1:0]       r_q, r_d, nr_q, nr_d;
  logic [TW-1:0]       tr_q, tr_d, cost_q, cost_d, maxw_q, maxw_d;
  logic                chg_q, chg_d, unr_q, unr_d, force_q, force_d;
  logic [SW-1:0]       gsum_q, gsum_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Memories and their registered read data.
  logic [GenWidth-1:0] gen_mem  [MaxGen];
  logic [RW-1:0]       gmod_mem [MaxGen];
  logic [TW-1:0]       tab_mem  [MaxMult];
  logic [GenWidth-1:0] gen_rd_q;
  logic [RW-1:0]       gmod_rd_q;
  logic [TW-1:0]       tab_rd_q;
  logic                gen_we, gmod_we, tab_we;
  logic [RW-1:0]       tab_waddr, tab_raddr;
  logic [TW-1:0]       tab_wdata;

  logic             div_start, div_done;
  logic [TW-1:0]    div_divd, div_quo;
  logic [MW-1:0]    div_rem, m_w;
  logic [RW-1:0]    m_m1;
  logic [RW:0]      nsum, m_e;
  logic             chg_n, wrote;
  logic signed [CW-1:0] frob_full;
  logic [FROB_W-1:0]    frob_res;
  logic [GENUS_W-1:0]   genus_res;
  status_e              st_res;

  assign m_w  = MW'(min_q);
  assign m_m1 = RW'(min_q - 1'b1);
  assign m_e  = (RW + 1)'(m_w);
  assign nsum = {1'b0, r_q} + {1'b0, gmod_rd_q};
  assign frob_full = $signed(CW'(maxw_q)) - $signed(CW'(min_q));

  afg_div #(.DivdW(TW), .DivsW(MW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_divd),
    .divisor_i  (m_w),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Result of the evaluation, from the flags and the sweep registers.
  always_comb begin
    frob_res  = '0;
    genus_res = '0;
    st_res    = ST_OK;
    if (force_q) begin
      frob_res  = FROB_W'(RANGE_MAX);
      genus_res = GENUS_W'(RANGE_MAX);
      st_res    = ST_OVERFLOW;
    end else if (unr_q) begin
      st_res = ST_UNREACH;
    end else if (min_q == GenWidth'(1)) begin
      frob_res = '1;
    end else if (frob_full > $signed(CW'(RANGE_MAX))) begin
      frob_res  = FROB_W'(RANGE_MAX);
      genus_res = GENUS_W'(RANGE_MAX);
      st_res    = ST_OVERFLOW;
    end else if (frob_full < 0) begin
      frob_res = '1;
    end else begin
      // Selmer: the genus is the sum of floor(w / m) over the Apery set.
      frob_res  = FROB_W'(frob_full);
      genus_res = GENUS_W'(gsum_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    min_d       = min_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    r_d         = r_q;
    nr_d        = nr_q;
    tr_d        = tr_q;
    cost_d      = cost_q;
    maxw_d      = maxw_q;
    chg_d       = chg_q;
    unr_d       = unr_q;
    force_d     = force_q;
    gsum_d      = gsum_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    gen_we      = 1'b0;
    gmod_we     = 1'b0;
    tab_we      = 1'b0;
    tab_waddr   = r_q;
    tab_wdata   = INF;
    tab_raddr   = r_q;
    div_start   = 1'b0;
    div_divd    = TW'(gen_rd_q);
    cmd_ready_o = 1'b0;
    chg_n       = chg_q;
    wrote       = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_ctl_i.store) begin
            if (cnt_q < CNW'(MaxGen)) begin
              gen_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            if (cmd_gen_i < min_q) begin
              min_d = cmd_gen_i;
            end
          end
          if (cmd_ctl_i.last) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        k_d     = '0;
        r_d     = '0;
        maxw_d  = '0;
        gsum_d  = '0;
        unr_d   = 1'b0;
        force_d = 1'b0;
        if (ovf_q) begin
          force_d = 1'b1;
          state_d = S_FIN;
        end else if (cnt_q == '0) begin
          unr_d   = 1'b1;
          state_d = S_FIN;
        end else if (int'(min_q) > MaxMult) begin
          force_d = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_GM_RD;
        end
      end
      // Reduce every stored generator modulo m.
      S_GM_RD: state_d = S_GM_ST;
      S_GM_ST: begin
        div_start = 1'b1;
        state_d   = S_GM_DIV;
      end
      S_GM_DIV: begin
        if (div_done) begin
          gmod_we = 1'b1;
          if (k_q == KW'(cnt_q - 1'b1)) begin
            r_d     = '0;
            state_d = S_INIT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_GM_RD;
          end
        end
      end
      S_INIT: begin
        tab_we    = 1'b1;
        tab_wdata = (r_q == '0) ? '0 : INF;
        if (r_q == m_m1) begin
          r_d     = '0;
          chg_d   = 1'b0;
          state_d = S_R_RD;
        end else begin
          r_d = r_q + 1'b1;
        end
      end
      // Relaxation passes, repeated until one pass changes nothing.
      S_R_RD: state_d = S_R_CHK;
      S_R_CHK: begin
        tr_d = tab_rd_q;
        k_d  = '0;
        if (tab_rd_q != INF) begin
          state_d = S_K_RD;
        end else if (r_q != m_m1) begin
          r_d     = r_q + 1'b1;
          state_d = S_R_RD;
        end else if (chg_q) begin
          r_d     = '0;
          chg_d   = 1'b0;
          state_d = S_R_RD;
        end else begin
          r_d     = '0;
          state_d = S_SW_RD;
        end
      end
      S_K_RD: state_d = S_K_CALC;
      S_K_CALC: begin
        nr_d      = RW'((nsum >= m_e) ? nsum - m_e : nsum);
        cost_d    = tr_q + TW'(gen_rd_q);
        tab_raddr = nr_d;
        state_d   = S_K_UPD;
      end
      S_K_UPD: begin
        if (cost_q < tab_rd_q) begin
          tab_we    = 1'b1;
          tab_waddr = nr_q;
          tab_wdata = cost_q;
          wrote     = 1'b1;
        end
        chg_n = chg_q | wrote;
        chg_d = chg_n;
        if (k_q != KW'(cnt_q - 1'b1)) begin
          k_d     = k_q + 1'b1;
          state_d = S_K_RD;
        end else if (r_q != m_m1) begin
          r_d     = r_q + 1'b1;
          state_d = S_R_RD;
        end else if (chg_n) begin
          r_d     = '0;
          chg_d   = 1'b0;
          state_d = S_R_RD;
        end else begin
          r_d     = '0;
          state_d = S_SW_RD;
        end
      end
      // Sweep: reachability, largest entry and the quotient sum.
      S_SW_RD: state_d = S_SW_CHK;
      S_SW_CHK: begin
        if (tab_rd_q == INF) begin
          unr_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          if (tab_rd_q > maxw_q) begin
            maxw_d = tab_rd_q;
          end
          div_divd  = tab_rd_q;
          div_start = 1'b1;
          state_d   = S_SW_DIV;
        end
      end
      S_SW_DIV: begin
        if (div_done) begin
          gsum_d = gsum_q + SW'(div_quo);
          if (r_q == m_m1) begin
            state_d = S_FIN;
          end else begin
            r_d     = r_q + 1'b1;
            state_d = S_SW_RD;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_W'({st_res, genus_res, frob_res});
          cnt_d       = '0;
          min_d       = '1;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      min_q       <= '1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    r_q        <= r_d;
    nr_q       <= nr_d;
    tr_q       <= tr_d;
    cost_q     <= cost_d;
    maxw_q     <= maxw_d;
    chg_q      <= chg_d;
    unr_q      <= unr_d;
    force_q    <= force_d;
    gsum_q     <= gsum_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[cnt_q[KW-1:0]] <= cmd_gen_i;
    end
    gen_rd_q <= gen_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (gmod_we) begin
      gmod_mem[k_q] <= div_rem[RW-1:0];
    end
    gmod_rd_q <= gmod_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd_q <= tab_mem[tab_raddr];
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(MaxGen))
    else $error("generator count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K_CALC) |-> (tr_q != INF))
    else $error("relaxing from an unreached residue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not posted");

endmodule

### rtl/core/apery_frobenius_genus.sv
// ----------------------------------------------------------------------------
// apery_frobenius_genus
// Frobenius number and genus of a numerical semigroup from its generators.
// ----------------------------------------------------------------------------
//   channel   direction  fields (tdata from bit 0 up)
//   s_axis    in         generator; tlast marks the last generator
//   m_axis    out        frobenius[18:0], genus[36:19], status[38:37]
//
// A generator item is taken whenever the command queue has room.
// After the last item the back works on its own: it reduces each stored
// generator modulo m, sets up the Apery table, runs relaxation passes until
// one pass changes nothing, and closes with a sweep over every residue. The
// reduction and the sweep share one bit-serial divider, and the table has a
// single read port. Input stalls once the four-entry queue fills.
// Reset is asynchronous and active low; it empties the queue, clears the
// generator count and the overflow flag, and sets the smallest generator
// to all ones.
// ----------------------------------------------------------------------------
module apery_frobenius_genus #(
  parameter int unsigned MAX_GENERATORS   = afg_pkg::MAX_GENERATORS_DEF,
  parameter int unsigned MAX_MULTIPLICITY = afg_pkg::MAX_MULTIPLICITY_DEF,
  parameter int unsigned GENERATOR_WIDTH  = afg_pkg::GENERATOR_WIDTH_DEF,
  parameter int unsigned InTdataW         = ((GENERATOR_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [InTdataW-1:0]             s_axis_tdata_i,   // generator
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [afg_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o    // frobenius, genus, status
);
  import afg_pkg::*;

  localparam int unsigned QW = GENERATOR_WIDTH + $bits(cmd_ctl_t);

  logic                       push, full, q_valid, pop;
  logic [GENERATOR_WIDTH-1:0] f_gen, b_gen;
  cmd_ctl_t                   f_ctl, b_ctl;
  logic [QW-1:0]              q_rdata;

  // The front only classifies; every item that matters becomes a command.
  afg_front #(.GenWidth(GENERATOR_WIDTH), .TdataW(InTdataW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tlast_i   (s_axis_tlast_i),
    .cmd_valid_o (push),
    .cmd_full_i  (full),
    .cmd_gen_o   (f_gen),
    .cmd_ctl_o   (f_ctl)
  );

  afg_queue #(.Width(QW), .Depth(CMD_QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_ctl, f_gen}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (q_rdata)
  );

  assign b_gen = q_rdata[GENERATOR_WIDTH-1:0];
  assign b_ctl = cmd_ctl_t'(q_rdata[QW-1:GENERATOR_WIDTH]);

  // The back pops one command a cycle while idle and owns the result register.
  afg_back #(
    .MaxGen   (MAX_GENERATORS),
    .MaxMult  (MAX_MULTIPLICITY),
    .GenWidth (GENERATOR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (pop),
    .cmd_gen_i   (b_gen),
    .cmd_ctl_i   (b_ctl),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule
